// ===== hw/rtl/pte_pkg.sv =====
// Package for the primitive triangle expander: beat types, kind codes, widths.
package pte_pkg;

	localparam int CW = 24;
	localparam int TW = 16;

	localparam logic [1:0] KIND_RECT    = 2'd0;
	localparam logic [1:0] KIND_OUTLINE = 2'd1;
	localparam logic [1:0] KIND_SEGMENT = 2'd2;
	// Reserved code: accepted, gives no vertices
	localparam logic [1:0] KIND_NONE    = 2'd3;

	typedef struct packed {
		logic [1:0]           kind;
		logic signed [CW-1:0] first_x;
		logic signed [CW-1:0] first_y;
		logic signed [CW-1:0] second_x;
		logic signed [CW-1:0] second_y;
		logic [TW-1:0]        thickness;
	} prim_t;

	typedef struct packed {
		logic signed [CW-1:0] vertex_x;
		logic signed [CW-1:0] vertex_y;
		logic                 last;
	} vert_t;

	// Job handed from front to back: up to four rectangles, corner coordinates.
	// Segment quads reuse the l/t fields of the slots: FL, SL, FR, SR.
	typedef struct packed {
		logic [2:0]             nrect;
		logic signed [CW+2:0]   l0, r0, t0, b0;
		logic signed [CW+2:0]   l1, r1, t1, b1;
		logic signed [CW+2:0]   l2, r2, t2, b2;
		logic signed [CW+2:0]   l3, r3, t3, b3;
	} job_t;

endpackage

// ===== hw/rtl/pte_front.sv =====
// Front end: classifies primitives, computes segment normals with a serial sqrt/divide.
module pte_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  pte_pkg::prim_t in_beat,
	output logic           in_ready,
	output logic           job_valid,
	output pte_pkg::job_t  job,
	output logic           job_seg,
	input  logic           job_ready
);
	localparam int CW = pte_pkg::CW;
	localparam int XW = CW + 3;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQRT = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]             state_q;
	logic [5:0]             cnt_q;
	pte_pkg::prim_t         p_q;
	logic signed [CW:0]     dx_q, dy_q;
	logic [49:0]            rad_q;
	logic [25:0]            res_q;
	logic [26:0]            rem_q;
	logic [41:0]            num_q;
	logic [42:0]            drem_q;
	logic [41:0]            quo_q;
	logic                   xsel_q;
	logic                   nx_neg_q;
	logic signed [XW-1:0]   nx_q, ny_q;
	pte_pkg::job_t          job_q;
	logic                   seg_q;
	logic                   jv_q;
	logic                   jseg_q;

	logic signed [CW:0]     dx_c, dy_c;
	logic [CW-1:0]          ax_c, ay_c;
	logic [27:0]            trial_c;
	logic [28:0]            rem_sh_c;
	logic [43:0]            dtrial_c;
	logic [26:0]            den_c;
	logic signed [XW-1:0]   q_s;
	logic signed [XW-1:0]   x1, y1, x2, y2, tt;
	pte_pkg::job_t          jr_c, js_c;
	logic                   ld_c;

	assign in_ready  = (state_q == ST_IDLE);
	assign job_valid = jv_q;
	assign job       = job_q;
	assign job_seg   = jseg_q;
	// Built job moves into the one-entry job buffer when it is empty or draining
	assign ld_c      = (state_q == ST_OUT) && (!jv_q || job_ready);

	// Extended operands of the accepted primitive
	assign x1 = XW'(p_q.first_x);
	assign y1 = XW'(p_q.first_y);
	assign x2 = XW'(p_q.second_x);
	assign y2 = XW'(p_q.second_y);
	assign tt = XW'({1'b0, p_q.thickness});

	assign dx_c = (CW+1)'(in_beat.second_x) - (CW+1)'(in_beat.first_x);
	assign dy_c = (CW+1)'(in_beat.second_y) - (CW+1)'(in_beat.first_y);
	assign ax_c = dx_c[CW] ? CW'(-dx_c) : CW'(dx_c);
	assign ay_c = dy_c[CW] ? CW'(-dy_c) : CW'(dy_c);

	// Restoring sqrt step: two radicand bits a cycle
	assign rem_sh_c = {rem_q, rad_q[49:48]};
	assign trial_c  = {res_q, 2'b01};
	// Restoring divide step: one quotient bit a cycle
	assign den_c    = {res_q, 1'b0};
	assign dtrial_c = {drem_q, num_q[41]};

	// Rectangle and outline job building
	always_comb begin
		jr_c = '0;
		if (p_q.kind == pte_pkg::KIND_RECT) begin
			jr_c.nrect = 3'd1;
			jr_c.l0 = x1; jr_c.r0 = x1 + x2; jr_c.t0 = y1; jr_c.b0 = y1 + y2;
		end else begin
			jr_c.nrect = 3'd4;
			jr_c.l0 = x1; jr_c.r0 = x1 + x2; jr_c.t0 = y1; jr_c.b0 = y1 + tt;
			jr_c.l1 = x1; jr_c.r1 = x1 + x2; jr_c.t1 = y1 + y2 - tt;
			jr_c.b1 = y1 + y2;
			jr_c.l2 = x1; jr_c.r2 = x1 + tt; jr_c.t2 = y1 + tt;
			jr_c.b2 = y1 + y2 - tt;
			jr_c.l3 = x1 + x2 - tt; jr_c.r3 = x1 + x2; jr_c.t3 = y1 + tt;
			jr_c.b3 = y1 + y2 - tt;
		end
	end

	// Segment job: slots hold FL, SL, FR, SR in l/t of slots 0..3
	always_comb begin
		js_c = '0;
		js_c.nrect = 3'd1;
		js_c.l0 = x1 + nx_q; js_c.t0 = y1 + ny_q;
		js_c.l1 = x2 + nx_q; js_c.t1 = y2 + ny_q;
		js_c.l2 = x1 - nx_q; js_c.t2 = y1 - ny_q;
		js_c.l3 = x2 - nx_q; js_c.t3 = y2 - ny_q;
	end

	assign q_s = nx_neg_q ? -XW'(quo_q) : XW'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			jv_q    <= 1'b0;
		end else begin
			// Job buffer: filled from ST_OUT, emptied by the back end
			if (ld_c)
				jv_q <= 1'b1;
			else if (job_ready)
				jv_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					p_q  <= in_beat;
					dx_q <= dx_c;
					dy_q <= dy_c;
					if (in_beat.kind == pte_pkg::KIND_SEGMENT) begin
						if ((dx_c == '0 && dy_c == '0) || in_beat.thickness == '0)
							state_q <= ST_IDLE;
						else begin
							rad_q   <= 50'(ax_c) * 50'(ax_c) + 50'(ay_c) * 50'(ay_c);
							res_q   <= '0;
							rem_q   <= '0;
							cnt_q   <= 6'd25;
							state_q <= ST_SQRT;
						end
					end else if (in_beat.kind == pte_pkg::KIND_RECT ||
						in_beat.kind == pte_pkg::KIND_OUTLINE) begin
						cnt_q   <= '0;
						state_q <= ST_OUT;
						seg_q   <= 1'b0;
					end
				end
				ST_SQRT: begin
					rad_q <= {rad_q[47:0], 2'b00};
					if (rem_sh_c >= 29'(trial_c)) begin
						rem_q <= 27'(rem_sh_c - 29'(trial_c));
						res_q <= {res_q[24:0], 1'b1};
					end else begin
						rem_q <= 27'(rem_sh_c);
						res_q <= {res_q[24:0], 1'b0};
					end
					if (cnt_q == 6'd1) begin
						xsel_q  <= 1'b0;
						state_q <= ST_DIV;
						cnt_q   <= 6'd42;
						nx_neg_q <= !dy_q[CW];
						num_q   <= 42'(41'(dy_q[CW] ? -dy_q : dy_q) * 41'(p_q.thickness));
						drem_q  <= '0;
						quo_q   <= '0;
					end else
						cnt_q <= cnt_q - 6'd1;
				end
				ST_DIV: begin
					if (cnt_q == 6'd0) begin
						// Quotient complete: keep it, start the second divide or finish
						if (!xsel_q) begin
							nx_q     <= q_s;
							xsel_q   <= 1'b1;
							cnt_q    <= 6'd42;
							num_q    <= 42'(41'(dx_q[CW] ? -dx_q : dx_q) * 41'(p_q.thickness));
							nx_neg_q <= dx_q[CW];
							drem_q   <= '0;
							quo_q    <= '0;
						end else begin
							ny_q    <= q_s;
							state_q <= ST_OUT;
							seg_q   <= 1'b1;
						end
					end else begin
						num_q <= {num_q[40:0], 1'b0};
						if (dtrial_c >= 44'(den_c)) begin
							drem_q <= 43'(dtrial_c - 44'(den_c));
							quo_q  <= {quo_q[40:0], 1'b1};
						end else begin
							drem_q <= 43'(dtrial_c);
							quo_q  <= {quo_q[40:0], 1'b0};
						end
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_OUT: begin
					// Wait for room in the job buffer
					if (ld_c)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Job buffer contents
	always_ff @(posedge clk) begin
		if (ld_c) begin
			job_q  <= seg_q ? js_c : jr_c;
			jseg_q <= seg_q;
		end
	end
endmodule

// ===== hw/rtl/pte_back.sv =====
// Back end: walks a queued job and emits one saturated vertex per cycle.
module pte_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  pte_pkg::job_t  job,
	input  logic           job_seg,
	output logic           job_ready,
	output logic           out_strobe,
	output pte_pkg::vert_t out_beat
);
	localparam int CW = pte_pkg::CW;
	localparam int XW = CW + 3;
	localparam logic signed [XW-1:0] VMAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [XW-1:0] VMIN = {{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic                 act_q;
	pte_pkg::job_t        j_q;
	logic                 seg_q;
	logic [1:0]           rect_q;
	logic [2:0]           vert_q;
	logic [1:0]           rlast_c;
	logic                 last_c;
	logic signed [XW-1:0] l, r, t, b, vx, vy;
	pte_pkg::vert_t       beat_q;
	logic                 stb_q;

	// Last vertex of the job: sixth vertex of the final rectangle
	assign rlast_c   = (j_q.nrect == 3'd4) ? 2'd3 : 2'd0;
	assign last_c    = (vert_q == 3'd5) && (rect_q == rlast_c);
	assign job_ready = !act_q || last_c;

	// Corner select for the current vertex
	always_comb begin
		case (rect_q)
			2'd0: begin l = j_q.l0; r = j_q.r0; t = j_q.t0; b = j_q.b0; end
			2'd1: begin l = j_q.l1; r = j_q.r1; t = j_q.t1; b = j_q.b1; end
			2'd2: begin l = j_q.l2; r = j_q.r2; t = j_q.t2; b = j_q.b2; end
			default: begin l = j_q.l3; r = j_q.r3; t = j_q.t3; b = j_q.b3; end
		endcase
		if (seg_q) begin
			case (vert_q)
				3'd0: begin vx = j_q.l0; vy = j_q.t0; end
				3'd1, 3'd3: begin vx = j_q.l1; vy = j_q.t1; end
				3'd4: begin vx = j_q.l3; vy = j_q.t3; end
				default: begin vx = j_q.l2; vy = j_q.t2; end
			endcase
		end else begin
			case (vert_q)
				3'd0: begin vx = l; vy = t; end
				3'd1, 3'd3: begin vx = r; vy = t; end
				3'd4: begin vx = r; vy = b; end
				default: begin vx = l; vy = b; end
			endcase
		end
	end

	function automatic logic signed [CW-1:0] sat(input logic signed [XW-1:0] v);
		if (v > VMAX) sat = VMAX[CW-1:0];
		else if (v < VMIN) sat = VMIN[CW-1:0];
		else sat = v[CW-1:0];
	endfunction

	// Vertex and rectangle counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			stb_q  <= 1'b0;
			rect_q <= '0;
			vert_q <= '0;
		end else begin
			stb_q <= act_q;
			if (job_ready) begin
				act_q  <= job_valid;
				rect_q <= '0;
				vert_q <= '0;
			end else if (vert_q == 3'd5) begin
				rect_q <= rect_q + 2'd1;
				vert_q <= '0;
			end else
				vert_q <= vert_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			j_q   <= job;
			seg_q <= job_seg;
		end
		beat_q.vertex_x <= sat(vx);
		beat_q.vertex_y <= sat(vy);
		beat_q.last     <= last_c;
	end

	assign out_strobe = stb_q;
	assign out_beat   = beat_q;
endmodule

// ===== hw/rtl/primitive_triangle_expander_top.sv =====
// Top level of the primitive triangle expander.
// Takes one primitive at an edge where start is high and busy low, and emits its
// triangle-list vertices on result, one per cycle, each marked by result_strobe for one
// cycle; the receiver cannot stall and must take every vertex as it comes. A rectangle
// gives 6 vertices, an outline 24, a segment 6 or none, kind 3 none. For rectangles and
// outlines the first vertex passes the job buffer, the back end's job register and its
// output register. The back end emits one vertex a cycle while it holds a job; the front
// end takes a new primitive once the previous job has moved into its one-job buffer. A
// segment holds the front end (busy high) for a bit-serial square root, then two
// bit-serial divides, then the job build and its move into the buffer. Degenerate
// segments and kind 3 are taken without leaving the idle state.
module primitive_triangle_expander_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pte_pkg::prim_t prim,
	output logic           result_strobe,
	output pte_pkg::vert_t result
);
	logic          job_valid, job_ready, job_seg, in_ready;
	pte_pkg::job_t job;

	assign busy = !in_ready;

	pte_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .in_beat(prim),
		.in_ready(in_ready), .job_valid(job_valid), .job(job),
		.job_seg(job_seg), .job_ready(job_ready)
	);

	pte_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_seg(job_seg), .job_ready(job_ready),
		.out_strobe(result_strobe), .out_beat(result)
	);
endmodule
